FILE: rtl/core/tekd_pkg.sv
// Package for the terminal escape key decoder: widths, key codes, parse phases
// and the record passed from the front parser to the back stage. No dependencies.
`default_nettype none
package tekd_pkg;
  localparam int NUMBER_BITS = 12;
  localparam int TIME_BITS = 16;
  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_IDLE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_RESIZE = 2'd3;

  localparam logic [3:0] MD_META = 4'd1;
  localparam logic [3:0] MD_CTRL = 4'd2;
  localparam logic [3:0] MD_ALT = 4'd4;
  localparam logic [3:0] MD_SHIFT = 4'd8;

  localparam logic [7:0] K_TAB = 8'd9;
  localparam logic [7:0] K_ESC = 8'd27;
  localparam logic [7:0] K_F0 = 8'd128;
  localparam logic [7:0] K_INSERT = 8'd141;
  localparam logic [7:0] K_DELETE = 8'd142;
  localparam logic [7:0] K_HOME = 8'd143;
  localparam logic [7:0] K_END = 8'd144;
  localparam logic [7:0] K_PGUP = 8'd145;
  localparam logic [7:0] K_PGDN = 8'd146;
  localparam logic [7:0] K_UP = 8'd147;
  localparam logic [7:0] K_DOWN = 8'd148;
  localparam logic [7:0] K_LEFT = 8'd149;
  localparam logic [7:0] K_RIGHT = 8'd150;
  localparam logic [7:0] M_LPRESS = 8'd151;
  localparam logic [7:0] M_RPRESS = 8'd152;
  localparam logic [7:0] M_MPRESS = 8'd153;
  localparam logic [7:0] M_LDRAG = 8'd154;
  localparam logic [7:0] M_RDRAG = 8'd155;
  localparam logic [7:0] M_MDRAG = 8'd156;
  localparam logic [7:0] M_LREL = 8'd157;
  localparam logic [7:0] M_RREL = 8'd158;
  localparam logic [7:0] M_MREL = 8'd159;
  localparam logic [7:0] M_WHEEL_UP = 8'd163;
  localparam logic [7:0] M_WHEEL_DOWN = 8'd164;
  localparam logic [7:0] K_RESIZE = 8'd165;
  localparam logic [8:0] NO_KEY = 9'd511;
  localparam logic [15:0] DCLICK_RESET = 16'd200;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ESC = 4'd1;
  localparam logic [3:0] PH_CSI = 4'd2;
  localparam logic [3:0] PH_NUM = 4'd3;
  localparam logic [3:0] PH_MOD = 4'd4;
  localparam logic [3:0] PH_MB = 4'd5;
  localparam logic [3:0] PH_MX = 4'd6;
  localparam logic [3:0] PH_MY = 4'd7;
  localparam logic [3:0] PH_SS3 = 4'd8;

  typedef logic [NUMBER_BITS-1:0] num_t;

  // Job from the parser: either a finished result, a mouse report whose
  // release/double-click decision belongs to the back stage, or a millisecond
  // tick that advances the double-click timer in order with the releases.
  typedef struct packed {
    logic        is_tick;
    logic        is_mouse;
    logic        release_f;
    logic        status;
    logic [7:0]  key_code;
    logic [3:0]  modifiers;
    logic [12:0] mouse_x;
    logic [12:0] mouse_y;
    logic [6:0]  button;
  } job_t;

  // Saturating decimal accumulate: n*10+d, clamped to the number range.
  function automatic num_t accumulate(input num_t n, input logic [3:0] d);
    logic [NUMBER_BITS+4:0] v;
    v = {n, 3'b000} + {2'b00, n, 1'b0} + (NUMBER_BITS+5)'(d);
    if (v > (NUMBER_BITS+5)'({NUMBER_BITS{1'b1}})) begin
      return {NUMBER_BITS{1'b1}};
    end
    return v[NUMBER_BITS-1:0];
  endfunction

  // xterm modifier parameter to a modifier mask.
  function automatic logic [3:0] param_mods(input num_t n);
    num_t m;
    m = (n == '0) ? '0 : n - num_t'(1);
    return {m[0], m[1], m[2], m[3]};
  endfunction

  // Zero-based coordinate from a one-based report, clamped at 4095.
  function automatic logic [12:0] coord(input num_t v);
    logic [12:0] c;
    c = (NUMBER_BITS > 12 && v > num_t'(4095)) ? 13'd4095 : 13'(v);
    return c - 13'd1;
  endfunction

  // Keys for CSI number ~ sequences; zero means not defined.
  function automatic logic [7:0] tilde_key(input num_t n);
    logic [7:0] k;
    k = 8'd0;
    if (n < num_t'(25)) begin
      case (n[4:0])
        5'd1, 5'd7: k = K_HOME;
        5'd2: k = K_INSERT;
        5'd3: k = K_DELETE;
        5'd4, 5'd8: k = K_END;
        5'd5: k = K_PGUP;
        5'd6: k = K_PGDN;
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: k = K_F0 + 8'(n[4:0] - 5'd10);
        5'd17, 5'd18, 5'd19, 5'd20, 5'd21: k = K_F0 + 8'(n[4:0] - 5'd11);
        5'd23, 5'd24: k = K_F0 + 8'(n[4:0] - 5'd12);
        default: k = 8'd0;
      endcase
    end
    return k;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/tekd_in_if.sv
// Valid/ready channel interfaces for input events and decoded results.
// Depends on nothing.
`default_nettype none
interface tekd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_value;
  modport source (output valid, command, byte_value, input ready);
  modport sink (input valid, command, byte_value, output ready);
endinterface

interface tekd_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  key_code;
  logic [3:0]  modifiers;
  logic [12:0] mouse_x;
  logic [12:0] mouse_y;
  modport source (output valid, status, key_code, modifiers, mouse_x, mouse_y, input ready);
  modport sink (input valid, status, key_code, modifiers, mouse_x, mouse_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/terminal_escape_key_decoder_core.sv
// Top level of the terminal escape key decoder: parser, job queue, back stage
// and the double-click register. Depends on tekd_pkg and the channel interfaces.
//
// Accepts one event (byte, idle timeout, millisecond tick or resize) every
// cycle while the queue has room and gives at most one decoded key per
// event. A result enters the two-entry queue when its event is accepted and
// moves on to the output register when the back stage pops it from the queue.
// While the output is stalled the input keeps flowing until two more jobs
// wait in the queue behind the held result, then input ready drops until the
// back stage drains. Millisecond ticks pass through the queue as jobs, so they
// reach the double-click timer in order with mouse releases; a tick takes a
// queue entry but gives no result and never waits for the output.
`default_nettype none
module terminal_escape_key_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tekd_in_if.sink          in_ch,
  tekd_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  logic [15:0]    dclick_r;
  logic           q_full, push, pop, q_ne;
  tekd_pkg::job_t push_job, head;

  // Double-click window register.
  always_ff @(posedge clk) begin
    if (!rst_n) dclick_r <= tekd_pkg::DCLICK_RESET;
    else if (cfg_we) dclick_r <= cfg_wdata;
  end

  tekd_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_byte_value(in_ch.byte_value),
    .q_full, .push, .push_job
  );

  tekd_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full), .pop,
    .not_empty(q_ne), .head
  );

  tekd_back u_back (
    .clk, .rst_n, .dclick_ms(dclick_r),
    .q_not_empty(q_ne), .q_head(head), .pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.status), .out_key_code(out_ch.key_code),
    .out_modifiers(out_ch.modifiers), .out_mouse_x(out_ch.mouse_x),
    .out_mouse_y(out_ch.mouse_y)
  );
endmodule
`default_nettype wire

FILE: rtl/core/tekd_front.sv
// Front parser: runs the escape-sequence state machine one event per cycle
// while the queue has room, and pushes jobs into it. Depends on tekd_pkg.
`default_nettype none
module tekd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_command,
  input  wire logic [7:0]       in_byte_value,
  input  wire logic             q_full,
  output logic                  push,
  output tekd_pkg::job_t        push_job
);
  logic [3:0]         phase_r, phase_nxt;
  tekd_pkg::num_t     code_r, code_nxt, mod_r, mod_nxt, btn_r, btn_nxt;
  tekd_pkg::num_t     col_r, col_nxt, row_r, row_nxt;
  logic               resize_r, resize_nxt;
  logic               fire, emit, digit;
  logic [3:0]         dval, pm;
  logic [7:0]         c, tk;
  tekd_pkg::job_t     job;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;
  assign c = in_byte_value;
  assign digit = c inside {["0":"9"]};
  assign dval = c[3:0];
  assign pm = tekd_pkg::param_mods(mod_r);
  assign tk = tekd_pkg::tilde_key(code_r);

  // Next-state and result decode for one event.
  always_comb begin
    phase_nxt = phase_r;
    code_nxt = code_r;
    mod_nxt = mod_r;
    btn_nxt = btn_r;
    col_nxt = col_r;
    row_nxt = row_r;
    resize_nxt = resize_r;
    emit = 1'b0;
    job = '0;
    job.mouse_x = '1;
    job.mouse_y = '1;
    job.button = 7'(btn_r);
    case (in_command)
      // Ticks travel through the queue so they stay in order with releases.
      tekd_pkg::CMD_TICK: begin
        emit = 1'b1;
        job.is_tick = 1'b1;
      end
      tekd_pkg::CMD_RESIZE: resize_nxt = 1'b1;
      tekd_pkg::CMD_IDLE: begin
        emit = 1'b1;
        phase_nxt = tekd_pkg::PH_IDLE;
        case (phase_r)
          tekd_pkg::PH_IDLE: begin
            emit = resize_r;
            resize_nxt = 1'b0;
            job.key_code = tekd_pkg::K_RESIZE;
          end
          tekd_pkg::PH_ESC: job.key_code = tekd_pkg::K_ESC;
          tekd_pkg::PH_CSI, tekd_pkg::PH_NUM, tekd_pkg::PH_MOD: begin
            job.key_code = "[";
            job.modifiers = tekd_pkg::MD_ALT;
          end
          default: job.status = 1'b1;
        endcase
      end
      default: begin
        emit = 1'b1;
        case (phase_r)
          tekd_pkg::PH_IDLE: begin
            if (c == tekd_pkg::K_ESC) begin
              emit = 1'b0;
              phase_nxt = tekd_pkg::PH_ESC;
            end
            job.key_code = c;
          end
          tekd_pkg::PH_ESC: begin
            if (c == tekd_pkg::K_ESC) begin
              job.key_code = tekd_pkg::K_ESC;
            end else if (c == "[") begin
              emit = 1'b0;
              code_nxt = '0;
              mod_nxt = '0;
              phase_nxt = tekd_pkg::PH_CSI;
            end else if (c == "P") begin
              job.status = 1'b1;
            end else if (c == "O") begin
              emit = 1'b0;
              phase_nxt = tekd_pkg::PH_SS3;
            end else begin
              job.key_code = c;
              job.modifiers = tekd_pkg::MD_ALT;
            end
          end
          tekd_pkg::PH_CSI, tekd_pkg::PH_NUM, tekd_pkg::PH_MOD: begin
            if (digit) begin
              emit = 1'b0;
              if (phase_r == tekd_pkg::PH_CSI) begin
                code_nxt = tekd_pkg::num_t'(dval);
                phase_nxt = tekd_pkg::PH_NUM;
              end else if (phase_r == tekd_pkg::PH_NUM) begin
                code_nxt = tekd_pkg::accumulate(code_r, dval);
              end else begin
                mod_nxt = tekd_pkg::accumulate(mod_r, dval);
              end
            end else if (c == ";" && phase_r == tekd_pkg::PH_NUM) begin
              emit = 1'b0;
              mod_nxt = '0;
              phase_nxt = tekd_pkg::PH_MOD;
            end else if (c == ";" && phase_r == tekd_pkg::PH_MOD) begin
              job.status = 1'b1;
            end else begin
              // Final byte of a CSI sequence.
              job.modifiers = pm;
              case (c)
                "A": job.key_code = tekd_pkg::K_UP;
                "B": job.key_code = tekd_pkg::K_DOWN;
                "C": job.key_code = tekd_pkg::K_RIGHT;
                "D": job.key_code = tekd_pkg::K_LEFT;
                "F": job.key_code = tekd_pkg::K_END;
                "H": job.key_code = tekd_pkg::K_HOME;
                "J": begin
                  job.key_code = tekd_pkg::K_HOME;
                  job.modifiers = tekd_pkg::MD_SHIFT;
                  job.status = (code_r != tekd_pkg::num_t'(2));
                end
                "K": begin
                  job.key_code = tekd_pkg::K_END;
                  job.modifiers = tekd_pkg::MD_SHIFT;
                end
                "M": begin
                  job.key_code = tekd_pkg::K_DELETE;
                  job.modifiers = tekd_pkg::MD_CTRL;
                end
                "P": job.key_code = (code_r == tekd_pkg::num_t'(1)) ?
                                    tekd_pkg::K_F0 + 8'd1 : tekd_pkg::K_DELETE;
                "Q", "R", "S": begin
                  job.key_code = tekd_pkg::K_F0 + 8'd2 + (c - "Q");
                  job.status = (code_r != tekd_pkg::num_t'(1));
                end
                "Z": begin
                  job.key_code = tekd_pkg::K_TAB;
                  job.modifiers = pm | tekd_pkg::MD_SHIFT;
                end
                "~": begin
                  job.key_code = tk;
                  job.status = (tk == 8'd0);
                end
                "<": begin
                  emit = 1'b0;
                  btn_nxt = '0;
                  col_nxt = '0;
                  row_nxt = '0;
                  phase_nxt = tekd_pkg::PH_MB;
                end
                default: job.status = 1'b1;
              endcase
            end
          end
          tekd_pkg::PH_MB, tekd_pkg::PH_MX: begin
            if (digit) begin
              emit = 1'b0;
              if (phase_r == tekd_pkg::PH_MB) btn_nxt = tekd_pkg::accumulate(btn_r, dval);
              else col_nxt = tekd_pkg::accumulate(col_r, dval);
            end else if (c == ";") begin
              emit = 1'b0;
              phase_nxt = (phase_r == tekd_pkg::PH_MB) ? tekd_pkg::PH_MX : tekd_pkg::PH_MY;
            end else begin
              job.status = 1'b1;
            end
          end
          tekd_pkg::PH_MY: begin
            if (digit) begin
              emit = 1'b0;
              row_nxt = tekd_pkg::accumulate(row_r, dval);
            end else if (c == "m" || c == "M") begin
              // Mouse report: key decision is finished in the back stage.
              job.is_mouse = 1'b1;
              job.release_f = (c == "m");
              job.mouse_x = tekd_pkg::coord(col_r);
              job.mouse_y = tekd_pkg::coord(row_r);
              job.modifiers = pm | (btn_r[2] ? tekd_pkg::MD_SHIFT : 4'd0)
                            | (btn_r[3] ? tekd_pkg::MD_META : 4'd0)
                            | (btn_r[4] ? tekd_pkg::MD_CTRL : 4'd0);
              if (btn_r > tekd_pkg::num_t'(127)) job.button = 7'h7f;
            end else begin
              job.status = 1'b1;
            end
          end
          tekd_pkg::PH_SS3: begin
            if (c inside {["P":"S"]}) job.key_code = tekd_pkg::K_F0 + 8'd1 + (c - "P");
            else job.status = 1'b1;
          end
          default: job.status = 1'b1;
        endcase
        if (emit) phase_nxt = tekd_pkg::PH_IDLE;
      end
    endcase
    if (job.status && !job.is_mouse) begin
      job.key_code = 8'd0;
      job.modifiers = 4'd0;
    end
  end

  assign push = fire && emit;
  assign push_job = job;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tekd_pkg::PH_IDLE;
      code_r <= '0;
      mod_r <= '0;
      btn_r <= '0;
      col_r <= '0;
      row_r <= '0;
      resize_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      code_r <= code_nxt;
      mod_r <= mod_nxt;
      btn_r <= btn_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      resize_r <= resize_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/tekd_queue.sv
// Two-entry job queue between the parser and the back stage.
// Depends on tekd_pkg.
`default_nettype none
module tekd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tekd_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output tekd_pkg::job_t       head
);
  tekd_pkg::job_t mem_r [tekd_pkg::QDEPTH];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full = (cnt_r == 2'(tekd_pkg::QDEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign head = mem_r[rp_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/tekd_back.sv
// Back stage: finishes mouse decoding with double-click tracking and holds
// the output register. Depends on tekd_pkg.
`default_nettype none
module tekd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [15:0]      dclick_ms,
  input  wire logic             q_not_empty,
  input  wire tekd_pkg::job_t   q_head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_status,
  output logic [7:0]            out_key_code,
  output logic [3:0]            out_modifiers,
  output logic [12:0]           out_mouse_x,
  output logic [12:0]           out_mouse_y
);
  logic [8:0]                     last_r, last_nxt;
  logic [tekd_pkg::TIME_BITS-1:0] since_r, since_nxt;
  logic                           valid_r;
  logic                           st_r;
  logic [7:0]                     key_r;
  logic [3:0]                     mods_r;
  logic [12:0]                    mx_r, my_r;
  logic                           st_nxt;
  logic [7:0]                     key_nxt;
  logic                           is_rel;
  logic [6:0]                     b;

  // A tick job gives no result, so it never waits for the output register.
  assign pop = q_not_empty && (q_head.is_tick || !valid_r || out_ready);
  assign b = q_head.button & ~7'd28;

  // Key selection for a mouse report and the release tracker.
  always_comb begin
    st_nxt = q_head.status;
    key_nxt = q_head.key_code;
    is_rel = 1'b0;
    last_nxt = last_r;
    since_nxt = since_r;
    if (pop && q_head.is_tick && since_r != '1) since_nxt = since_r + 1'b1;
    if (q_head.is_mouse) begin
      st_nxt = 1'b0;
      case (b)
        7'd0: begin key_nxt = q_head.release_f ? tekd_pkg::M_LREL : tekd_pkg::M_LPRESS;
          is_rel = q_head.release_f; end
        7'd1: begin key_nxt = q_head.release_f ? tekd_pkg::M_MREL : tekd_pkg::M_MPRESS;
          is_rel = q_head.release_f; end
        7'd2: begin key_nxt = q_head.release_f ? tekd_pkg::M_RREL : tekd_pkg::M_RPRESS;
          is_rel = q_head.release_f; end
        7'd32: key_nxt = tekd_pkg::M_LDRAG;
        7'd33: key_nxt = tekd_pkg::M_MDRAG;
        7'd34: key_nxt = tekd_pkg::M_RDRAG;
        7'd64: key_nxt = tekd_pkg::M_WHEEL_UP;
        7'd65: key_nxt = tekd_pkg::M_WHEEL_DOWN;
        default: begin
          st_nxt = 1'b1;
          key_nxt = 8'd0;
        end
      endcase
      if (pop && is_rel) begin
        if ({1'b0, key_nxt} == last_r &&
            since_r < tekd_pkg::TIME_BITS'(dclick_ms)) key_nxt = key_nxt + 8'd3;
        last_nxt = {1'b0, key_nxt};
        since_nxt = '0;
      end
    end
  end

  // Tracker registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= tekd_pkg::NO_KEY;
      since_r <= '1;
      valid_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
      since_r <= since_nxt;
      if (pop && !q_head.is_tick) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !q_head.is_tick) begin
      st_r <= st_nxt;
      key_r <= key_nxt;
      mods_r <= st_nxt ? 4'd0 : q_head.modifiers;
      mx_r <= q_head.mouse_x;
      my_r <= q_head.mouse_y;
    end
  end

  assign out_valid = valid_r;
  assign out_status = st_r;
  assign out_key_code = key_r;
  assign out_modifiers = mods_r;
  assign out_mouse_x = mx_r;
  assign out_mouse_y = my_r;
endmodule
`default_nettype wire

FILE: rtl/core/tekd_checker.sv
// Port-level checker for the decoder top level, attached by bind.
// Depends on tekd_pkg.
`default_nettype none
module tekd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_status,
  input wire logic [7:0]  out_key_code,
  input wire logic [3:0]  out_modifiers,
  input wire logic [12:0] out_mouse_x
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_code))
    else $error("result changed while stalled");
  // Invalid results carry no modifiers.
  a_bad_mods: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_modifiers == 4'd0)
    else $error("invalid result with modifiers");
  // Invalid results carry key code zero.
  a_bad_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_key_code == 8'd0)
    else $error("invalid result with key");
  // Non-mouse keys have no column.
  a_nomouse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && out_key_code < tekd_pkg::M_LPRESS |-> out_mouse_x == '1)
    else $error("key result with mouse column");
  // No valid output right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid result after reset");
endmodule

bind terminal_escape_key_decoder_core tekd_checker u_tekd_checker (
  .clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_key_code(out_ch.key_code), .out_modifiers(out_ch.modifiers),
  .out_mouse_x(out_ch.mouse_x)
);
`default_nettype wire

FILE: sim/terminal_escape_key_decoder_core_tb.sv
// Self-checking testbench for terminal_escape_key_decoder_core: directed rows, then random
// key, mouse and timing traffic, checked against an in-bench model of the decoder.
// Depends on tekd_pkg, tekd_in_if, tekd_out_if and the decoder core.
`default_nettype none
module terminal_escape_key_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CAP = 4095;
  localparam int MS_CAP = 65535;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic        status;
    logic [7:0]  key_code;
    logic [3:0]  modifiers;
    logic [12:0] mouse_x;
    logic [12:0] mouse_y;
  } key_event_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] b;
    bit         typed;
    bit         has;
    key_event_t ev;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  tekd_in_if in_ch ();
  tekd_out_if out_ch ();

  terminal_escape_key_decoder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Decoder state as the testbench sees it.
  logic [3:0] phase_q;
  int code_n, mod_n, btn_n, col_n, row_n;
  int last_release, ms_since_release, dclick_ms;
  bit resize_waiting;

  key_event_t expected_keys[$];
  int src_idle, sink_idle;
  int mismatches, items_sent, keys_seen, double_clicks, invalid_seen;
  int quiet_cycles;
  stim_row_t rows[$];

  // Clock and output back-pressure.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    key_event_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.key_code, out_ch.modifiers, out_ch.mouse_x,
              out_ch.mouse_y};
      keys_seen++;
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected key event %p", got);
        end
      end else begin
        want = expected_keys.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("key event mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("terminal_escape_key_decoder_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int add_digit(int n, int d);
    int v;
    v = n * 10 + d;
    return (v > NUM_CAP) ? NUM_CAP : v;
  endfunction

  function automatic logic [3:0] xterm_mods(int n);
    int m;
    logic [3:0] r;
    m = (n != 0) ? n - 1 : 0;
    r = '0;
    if (m & 1) r |= tekd_pkg::MD_SHIFT;
    if (m & 2) r |= tekd_pkg::MD_ALT;
    if (m & 4) r |= tekd_pkg::MD_CTRL;
    if (m & 8) r |= tekd_pkg::MD_META;
    return r;
  endfunction

  function automatic logic [12:0] to_coord(int v);
    return 13'((v > 4095 ? 4095 : v) - 1);
  endfunction

  function automatic key_event_t mk_key(logic [7:0] k, logic [3:0] m);
    return '{1'b0, k, m, 13'h1FFF, 13'h1FFF};
  endfunction

  function automatic key_event_t mk_bad();
    return '{1'b1, 8'd0, 4'd0, 13'h1FFF, 13'h1FFF};
  endfunction

  function automatic logic [7:0] tilde_code(int n);
    case (n)
      1, 7: return tekd_pkg::K_HOME;
      2: return tekd_pkg::K_INSERT;
      3: return tekd_pkg::K_DELETE;
      4, 8: return tekd_pkg::K_END;
      5: return tekd_pkg::K_PGUP;
      6: return tekd_pkg::K_PGDN;
      10, 11, 12, 13, 14, 15: return tekd_pkg::K_F0 + 8'(n - 10);
      17, 18, 19, 20, 21: return tekd_pkg::K_F0 + 8'(n - 11);
      23, 24: return tekd_pkg::K_F0 + 8'(n - 12);
      default: return 8'd0;
    endcase
  endfunction

  // Final byte of a CSI key sequence.
  function automatic bit csi_end(logic [7:0] c, output key_event_t r);
    logic [3:0] m;
    m = xterm_mods(mod_n);
    case (c)
      "A": r = mk_key(tekd_pkg::K_UP, m);
      "B": r = mk_key(tekd_pkg::K_DOWN, m);
      "C": r = mk_key(tekd_pkg::K_RIGHT, m);
      "D": r = mk_key(tekd_pkg::K_LEFT, m);
      "F": r = mk_key(tekd_pkg::K_END, m);
      "H": r = mk_key(tekd_pkg::K_HOME, m);
      "J": r = (code_n == 2) ? mk_key(tekd_pkg::K_HOME, tekd_pkg::MD_SHIFT) : mk_bad();
      "K": r = mk_key(tekd_pkg::K_END, tekd_pkg::MD_SHIFT);
      "M": r = mk_key(tekd_pkg::K_DELETE, tekd_pkg::MD_CTRL);
      "P": r = mk_key((code_n == 1) ? tekd_pkg::K_F0 + 8'd1 : tekd_pkg::K_DELETE, m);
      "Q", "R", "S": r = (code_n == 1) ?
                         mk_key(tekd_pkg::K_F0 + 8'd2 + (c - 8'h51), m) : mk_bad();
      "Z": r = mk_key(tekd_pkg::K_TAB, m | tekd_pkg::MD_SHIFT);
      "~": r = (tilde_code(code_n) != 0) ? mk_key(tilde_code(code_n), m) : mk_bad();
      "<": begin
        btn_n = 0;
        col_n = 0;
        row_n = 0;
        phase_q = tekd_pkg::PH_MB;
        return 1'b0;
      end
      default: r = mk_bad();
    endcase
    return 1'b1;
  endfunction

  // End of a mouse report, with the double-click rule for releases.
  function automatic key_event_t mouse_end(bit up);
    logic [12:0] mx, my;
    logic [3:0] m;
    int k;
    mx = to_coord(col_n);
    my = to_coord(row_n);
    m = xterm_mods(mod_n);
    if (btn_n & 4) m |= tekd_pkg::MD_SHIFT;
    if (btn_n & 8) m |= tekd_pkg::MD_META;
    if (btn_n & 16) m |= tekd_pkg::MD_CTRL;
    case (btn_n & ~28)
      0: k = up ? tekd_pkg::M_LREL : tekd_pkg::M_LPRESS;
      1: k = up ? tekd_pkg::M_MREL : tekd_pkg::M_MPRESS;
      2: k = up ? tekd_pkg::M_RREL : tekd_pkg::M_RPRESS;
      32: k = tekd_pkg::M_LDRAG;
      33: k = tekd_pkg::M_MDRAG;
      34: k = tekd_pkg::M_RDRAG;
      64: k = tekd_pkg::M_WHEEL_UP;
      65: k = tekd_pkg::M_WHEEL_DOWN;
      default: return '{1'b1, 8'd0, 4'd0, mx, my};
    endcase
    if (k == tekd_pkg::M_LREL || k == tekd_pkg::M_RREL || k == tekd_pkg::M_MREL) begin
      if (k == last_release && ms_since_release < dclick_ms) begin
        k += 3;
        double_clicks++;
      end
      last_release = k;
      ms_since_release = 0;
    end
    return '{1'b0, 8'(k), m, mx, my};
  endfunction

  // Advances the decoder state by one event; returns 1 when a key event results.
  function automatic bit decode_event(logic [1:0] cmd, logic [7:0] c, output key_event_t r);
    bit dig, has;
    dig = (c >= "0" && c <= "9");
    has = 1'b1;
    if (cmd == tekd_pkg::CMD_TICK) begin
      if (ms_since_release < MS_CAP) ms_since_release++;
      return 1'b0;
    end
    if (cmd == tekd_pkg::CMD_RESIZE) begin
      resize_waiting = 1'b1;
      return 1'b0;
    end
    if (cmd == tekd_pkg::CMD_IDLE) begin
      case (phase_q)
        tekd_pkg::PH_IDLE: begin
          if (!resize_waiting) return 1'b0;
          resize_waiting = 1'b0;
          r = mk_key(tekd_pkg::K_RESIZE, 4'd0);
        end
        tekd_pkg::PH_ESC: r = mk_key(tekd_pkg::K_ESC, 4'd0);
        tekd_pkg::PH_CSI, tekd_pkg::PH_NUM, tekd_pkg::PH_MOD:
          r = mk_key("[", tekd_pkg::MD_ALT);
        default: r = mk_bad();
      endcase
      phase_q = tekd_pkg::PH_IDLE;
      return 1'b1;
    end
    case (phase_q)
      tekd_pkg::PH_IDLE: begin
        if (c == tekd_pkg::K_ESC) begin
          phase_q = tekd_pkg::PH_ESC;
          has = 1'b0;
        end else begin
          r = mk_key(c, 4'd0);
        end
      end
      tekd_pkg::PH_ESC: begin
        if (c == tekd_pkg::K_ESC) begin
          r = mk_key(tekd_pkg::K_ESC, 4'd0);
        end else if (c == "[") begin
          code_n = 0;
          mod_n = 0;
          phase_q = tekd_pkg::PH_CSI;
          has = 1'b0;
        end else if (c == "P") begin
          r = mk_bad();
        end else if (c == "O") begin
          phase_q = tekd_pkg::PH_SS3;
          has = 1'b0;
        end else begin
          r = mk_key(c, tekd_pkg::MD_ALT);
        end
      end
      tekd_pkg::PH_CSI: begin
        if (dig) begin
          code_n = c - "0";
          phase_q = tekd_pkg::PH_NUM;
          has = 1'b0;
        end else begin
          has = csi_end(c, r);
        end
      end
      tekd_pkg::PH_NUM: begin
        if (dig) begin
          code_n = add_digit(code_n, c - "0");
          has = 1'b0;
        end else if (c == ";") begin
          mod_n = 0;
          phase_q = tekd_pkg::PH_MOD;
          has = 1'b0;
        end else begin
          has = csi_end(c, r);
        end
      end
      tekd_pkg::PH_MOD: begin
        if (dig) begin
          mod_n = add_digit(mod_n, c - "0");
          has = 1'b0;
        end else if (c == ";") begin
          r = mk_bad();
        end else begin
          has = csi_end(c, r);
        end
      end
      tekd_pkg::PH_MB, tekd_pkg::PH_MX: begin
        has = 1'b0;
        if (dig && phase_q == tekd_pkg::PH_MB) begin
          btn_n = add_digit(btn_n, c - "0");
        end else if (dig) begin
          col_n = add_digit(col_n, c - "0");
        end else if (c == ";") begin
          phase_q = (phase_q == tekd_pkg::PH_MB) ? tekd_pkg::PH_MX : tekd_pkg::PH_MY;
        end else begin
          r = mk_bad();
          has = 1'b1;
        end
      end
      tekd_pkg::PH_MY: begin
        if (dig) begin
          row_n = add_digit(row_n, c - "0");
          has = 1'b0;
        end else if (c == "m" || c == "M") begin
          r = mouse_end(c == "m");
        end else begin
          r = mk_bad();
        end
      end
      default: begin
        if (c >= "P" && c <= "S") r = mk_key(tekd_pkg::K_F0 + 8'd1 + (c - "P"), 4'd0);
        else r = mk_bad();
      end
    endcase
    if (has) begin
      phase_q = tekd_pkg::PH_IDLE;
      if (r.status) invalid_seen++;
    end
    return has;
  endfunction

  // Hands one event to the block, with random sender gaps; returns the predicted key.
  task automatic offer(logic [1:0] cmd, logic [7:0] b, output bit has, output key_event_t r);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    has = decode_event(cmd, b, r);
    items_sent++;
  endtask

  task automatic send(logic [1:0] cmd, logic [7:0] b);
    bit has;
    key_event_t r;
    offer(cmd, b, has, r);
    if (has) expected_keys.push_back(r);
  endtask

  task automatic send_byte(logic [7:0] b);
    send(tekd_pkg::CMD_BYTE, b);
  endtask

  // Decimal digits of v; a negative v sends nothing.
  task automatic send_number(int v);
    string s;
    if (v >= 0) begin
      s = $sformatf("%0d", v);
      foreach (s[i]) send_byte(s[i]);
    end
  endtask

  // Writes the double-click window once all pending keys have drained.
  task automatic write_dclick(logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dclick_ms = v;
  endtask

  task automatic add_row(logic [1:0] cmd, logic [7:0] b, bit typed = 0, bit has = 0,
                         key_event_t ev = '0);
    rows.push_back('{cmd, b, typed, has, ev});
  endtask

  function automatic int pick_number();
    case ($urandom_range(9))
      0: return -1;
      1: return $urandom_range(99999);
      2: return $urandom_range(4094, 4097);
      default: return $urandom_range(30);
    endcase
  endfunction

  // One random mouse report, mostly well formed.
  task automatic send_mouse(int btn);
    if ($urandom_range(3) == 0) begin
      send_number($urandom_range(16));
      send_byte(";");
      send_number($urandom_range(17));
    end
    send_byte("<");
    send_number(btn);
    send_byte(";");
    send_number(pick_number());
    send_byte(";");
    send_number(pick_number());
    case ($urandom_range(19))
      0: send_byte(8'($urandom_range(255)));
      1: send(tekd_pkg::CMD_IDLE, 8'($urandom));
      default: send_byte($urandom_range(1) ? "m" : "M");
    endcase
  endtask

  task automatic random_item();
    int kind, btn;
    string finals;
    finals = "ABCDFHJKMPQRSZ~";
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 18) begin
      send_byte(tekd_pkg::K_ESC);
      send_byte(8'($urandom_range(255)));
    end else if (kind < 38) begin
      send_byte(tekd_pkg::K_ESC);
      send_byte("[");
      send_number($urandom_range(5) == 0 ? pick_number() : $urandom_range(25));
      if ($urandom_range(1)) begin
        send_byte(";");
        send_number($urandom_range(4) == 0 ? pick_number() : $urandom_range(16));
        if ($urandom_range(15) == 0) send_byte(";");
      end
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else if ($urandom_range(11) == 0) send(tekd_pkg::CMD_IDLE, 8'd0);
      else send_byte(finals[$urandom_range(finals.len() - 1)]);
    end else if (kind < 43) begin
      send_byte(tekd_pkg::K_ESC);
      send_byte("O");
      if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(8'("P" + $urandom_range(3)));
    end else if (kind < 73) begin
      case ($urandom_range(9))
        0: btn = $urandom_range(127);
        1: btn = 32 + $urandom_range(2);
        2: btn = 64 + $urandom_range(1);
        3: btn = 3;
        default: btn = $urandom_range(2);
      endcase
      if ($urandom_range(3) == 0) btn += 4 * $urandom_range(7);
      send_byte(tekd_pkg::K_ESC);
      send_byte("[");
      send_mouse(btn);
    end else if (kind < 83) begin
      repeat ($urandom_range(1, 8)) send(tekd_pkg::CMD_TICK, 8'($urandom));
    end else if (kind < 87) begin
      send(tekd_pkg::CMD_IDLE, 8'($urandom));
    end else if (kind < 90) begin
      send(tekd_pkg::CMD_RESIZE, 8'($urandom));
      if ($urandom_range(1)) send(tekd_pkg::CMD_IDLE, 8'd0);
    end else if (kind < 95) begin
      // Sequence cut short by a timeout.
      send_byte(tekd_pkg::K_ESC);
      if ($urandom_range(1)) begin
        send_byte("[");
        if ($urandom_range(1)) begin
          send_byte("<");
          send_number($urandom_range(2));
          if ($urandom_range(1)) send_byte(";");
        end
      end else if ($urandom_range(1)) begin
        send_byte("O");
      end
      send(tekd_pkg::CMD_IDLE, 8'd0);
    end else begin
      send(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int target;
    bit has;
    key_event_t r;
    logic [15:0] windows[6];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= tekd_pkg::CMD_BYTE;
    in_ch.byte_value <= '0;
    src_idle = 0;
    sink_idle = 0;
    mismatches = 0;
    items_sent = 0;
    keys_seen = 0;
    double_clicks = 0;
    invalid_seen = 0;
    phase_q = tekd_pkg::PH_IDLE;
    code_n = 0;
    mod_n = 0;
    btn_n = 0;
    col_n = 0;
    row_n = 0;
    last_release = tekd_pkg::NO_KEY;
    ms_since_release = MS_CAP;
    dclick_ms = tekd_pkg::DCLICK_RESET;
    resize_waiting = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: typed results where they are obvious, predicted elsewhere.
    add_row(tekd_pkg::CMD_BYTE, 8'h00, 1, 1, mk_key(8'h00, 4'd0));
    add_row(tekd_pkg::CMD_BYTE, 8'hFF, 1, 1, mk_key(8'hFF, 4'd0));
    add_row(tekd_pkg::CMD_IDLE, 8'h00, 1, 0);
    add_row(tekd_pkg::CMD_RESIZE, 8'hAA, 1, 0);
    add_row(tekd_pkg::CMD_IDLE, 8'h55, 1, 1, mk_key(tekd_pkg::K_RESIZE, 4'd0));
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC, 1, 0);
    add_row(tekd_pkg::CMD_IDLE, 8'h00, 1, 1, mk_key(tekd_pkg::K_ESC, 4'd0));
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC, 1, 0);
    add_row(tekd_pkg::CMD_BYTE, "P", 1, 1, mk_bad());
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC, 1, 0);
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC, 1, 1, mk_key(tekd_pkg::K_ESC, 4'd0));
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC);
    add_row(tekd_pkg::CMD_BYTE, "[");
    add_row(tekd_pkg::CMD_BYTE, "1");
    add_row(tekd_pkg::CMD_BYTE, "5");
    add_row(tekd_pkg::CMD_BYTE, ";");
    add_row(tekd_pkg::CMD_BYTE, "9");
    add_row(tekd_pkg::CMD_BYTE, "~");
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC);
    add_row(tekd_pkg::CMD_BYTE, "O");
    add_row(tekd_pkg::CMD_BYTE, "S", 1, 1, mk_key(tekd_pkg::K_F0 + 8'd4, 4'd0));
    add_row(tekd_pkg::CMD_BYTE, tekd_pkg::K_ESC);
    add_row(tekd_pkg::CMD_BYTE, "[");
    add_row(tekd_pkg::CMD_IDLE, 8'h00, 1, 1, mk_key("[", tekd_pkg::MD_ALT));
    add_row(tekd_pkg::CMD_TICK, 8'h00);
    foreach (rows[i]) begin
      offer(rows[i].cmd, rows[i].b, has, r);
      if (rows[i].typed) begin
        if (rows[i].has) expected_keys.push_back(rows[i].ev);
      end else if (has) begin
        expected_keys.push_back(r);
      end
    end

    // Random phases over several double-click windows and idling patterns.
    windows = '{16'd0, 16'hFFFF, 16'd3, tekd_pkg::DCLICK_RESET, 16'($urandom), 16'd8};
    target = items_sent;
    for (int p = 0; p < 6; p++) begin
      write_dclick(windows[p]);
      case (p / 2)
        0: begin src_idle = 20; sink_idle = 54; end
        1: begin src_idle = 54; sink_idle = 20; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      target += RANDOM_ITEMS / 6;
      while (items_sent < target) random_item();
    end

    in_ch.valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d events; checked %0d key events, %0d invalid, %0d double clicks.",
             items_sent, keys_seen, invalid_seen, double_clicks);
    if (mismatches == 0) begin
      $display("terminal_escape_key_decoder_core test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("terminal_escape_key_decoder_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
